>>> design/mwrr_pkg.sv
// ----------------------------------------------------------------------------
// mwrr_pkg
// Shared types and constants of the missing weight row renormalizer: field
// widths, fixed-point constants, controller states and the command/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package mwrr_pkg;

    // field widths
    localparam int W_WIDTH   = 32;
    localparam int SRC_WIDTH = 64;
    localparam int TOL_WIDTH = 30;
    localparam int SUM_WIDTH = 38;

    // fixed-point constants in q2.30
    localparam logic signed [W_WIDTH-1:0] Q_ONE        = 32'sh4000_0000;
    localparam logic signed [W_WIDTH-1:0] Q_MINUS_ONE  = 32'shC000_0000;
    localparam logic signed [W_WIDTH-1:0] Q_ZERO       = 32'sh0000_0000;
    localparam logic signed [W_WIDTH-1:0] W_MAX        = 32'sh7FFF_FFFF;
    localparam logic signed [W_WIDTH-1:0] W_MIN        = 32'sh8000_0000;

    // divider geometry: 32 quotient bits, two per cycle
    localparam int QUO_WIDTH          = 32;
    localparam int DIV_BITS_PER_CYCLE = 2;
    localparam int DIV_CYCLES         = QUO_WIDTH / DIV_BITS_PER_CYCLE;
    localparam int DIV_CNT_W          = $clog2(DIV_CYCLES);
    localparam int DEN_WIDTH          = SUM_WIDTH + 1;
    localparam int NUM_WIDTH          = W_WIDTH + 31;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_MISSING_PATTERN = 1'b0,
        CFG_ZERO_TOLERANCE  = 1'b1
    } cfg_index_t;

    // controller states
    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_DECIDE,
        ST_READ,
        ST_LOAD,
        ST_DIV,
        ST_PUSH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic decide;
        logic rd;
        logic load_direct;
        logic div_start;
        logic div_take;
        logic push;
        logic clear_row;
    } mwrr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic row_close;
        logic need_div;
        logic div_done;
        logic out_free;
        logic last_entry;
    } mwrr_stat_t;

endpackage

>>> design/mwrr_divider.sv
// ----------------------------------------------------------------------------
// mwrr_divider
// Restoring divider, two quotient bits per cycle. Computes
// round(|w| * 2^30 / |sum|) with ties away from zero, applies the sign and
// saturates to the signed 32-bit range.
// ----------------------------------------------------------------------------
module mwrr_divider
    import mwrr_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic signed [W_WIDTH-1:0]   weight,
    input  logic [SUM_WIDTH-1:0]        sum_mag,
    input  logic                        sum_neg,
    output logic                        done,
    output logic signed [W_WIDTH-1:0]   result
);

    logic                   busy_reg;
    logic                   done_reg;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic [DEN_WIDTH-1:0]   den_reg;
    logic [DEN_WIDTH-1:0]   rem_reg;
    logic [QUO_WIDTH-1:0]   xlo_reg;
    logic [QUO_WIDTH-1:0]   quo_reg;
    logic                   ovf_reg;
    logic                   neg_reg;

    logic [W_WIDTH-1:0]     mag_w;
    logic [NUM_WIDTH-1:0]   num_full;
    logic [DEN_WIDTH-1:0]   den_init;
    logic [NUM_WIDTH-QUO_WIDTH-1:0] num_hi;
    logic [DEN_WIDTH-1:0]   rem_next;
    logic [QUO_WIDTH-1:0]   quo_next;
    logic [QUO_WIDTH-1:0]   xlo_next;
    logic                   big;

    // operand setup: numerator 2*|w|*2^30 + |sum|, denominator 2*|sum|
    always_comb begin
        mag_w    = weight[W_WIDTH-1] ? W_WIDTH'(-weight) : weight;
        num_full = {mag_w, 31'b0} + {{(NUM_WIDTH-SUM_WIDTH){1'b0}}, sum_mag};
        den_init = {sum_mag, 1'b0};
        num_hi   = num_full[NUM_WIDTH-1:QUO_WIDTH];
    end

    // two dependent restoring steps per cycle
    always_comb begin
        logic [DEN_WIDTH:0] r_sh;
        rem_next = rem_reg;
        quo_next = quo_reg;
        xlo_next = xlo_reg;
        for (int k = 0; k < DIV_BITS_PER_CYCLE; k++) begin
            r_sh     = {rem_next, xlo_next[QUO_WIDTH-1]};
            xlo_next = {xlo_next[QUO_WIDTH-2:0], 1'b0};
            if (r_sh >= {1'b0, den_reg}) begin
                rem_next = DEN_WIDTH'(r_sh - {1'b0, den_reg});
                quo_next = {quo_next[QUO_WIDTH-2:0], 1'b1};
            end else begin
                rem_next = r_sh[DEN_WIDTH-1:0];
                quo_next = {quo_next[QUO_WIDTH-2:0], 1'b0};
            end
        end
    end

    // control of the iteration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath of the iteration
    always_ff @(posedge aclk) begin
        if (start) begin
            den_reg <= den_init;
            rem_reg <= DEN_WIDTH'(num_hi);
            xlo_reg <= num_full[QUO_WIDTH-1:0];
            quo_reg <= '0;
            ovf_reg <= {{(DEN_WIDTH-(NUM_WIDTH-QUO_WIDTH)){1'b0}}, num_hi} >= den_init;
            neg_reg <= weight[W_WIDTH-1] ^ sum_neg;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            xlo_reg <= xlo_next;
        end
    end

    // sign and saturation
    always_comb begin
        big = ovf_reg | quo_reg[QUO_WIDTH-1];
        if (neg_reg) begin
            result = big ? W_MIN : W_WIDTH'(-quo_reg);
        end else begin
            result = big ? W_MAX : quo_reg;
        end
    end

    assign done = done_reg;

endmodule

>>> design/mwrr_datapath.sv
// ----------------------------------------------------------------------------
// mwrr_datapath
// Row store, row statistics, configuration registers, result selection and
// the output register of the renormalizer.
// ----------------------------------------------------------------------------
module mwrr_datapath
    import mwrr_pkg::*;
#(
    parameter int MAX_ROW_ENTRIES = 32
)
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  mwrr_cmd_t               cmd,
    output mwrr_stat_t              stat,
    input  logic                    cfg_we,
    input  logic [0:0]              cfg_index,
    input  logic [SRC_WIDTH-1:0]    cfg_wdata,
    input  logic [95:0]             s_tdata,
    input  logic                    s_tlast,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [31:0]             m_tdata,
    output logic                    m_tlast,
    output logic                    m_tuser
);

    localparam int IDX_W = $clog2(MAX_ROW_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ROW_ENTRIES + 1);

    // configuration
    logic [SRC_WIDTH-1:0]           pattern_reg;
    logic [TOL_WIDTH-1:0]           tol_reg;

    // row statistics
    logic [CNT_W-1:0]               entry_count_reg,  entry_count_next;
    logic [CNT_W-1:0]               missing_count_reg, missing_count_next;
    logic signed [SUM_WIDTH-1:0]    kept_sum_reg,     kept_sum_next;
    logic signed [W_WIDTH-1:0]      heavy_w_reg,      heavy_w_next;
    logic                           heavy_miss_reg,   heavy_miss_next;
    logic [IDX_W-1:0]               last_miss_reg,    last_miss_next;

    // row decision
    logic                           changed_reg;
    logic                           one_hot_reg;
    logic [SUM_WIDTH-1:0]           sum_mag_reg;
    logic                           sum_neg_reg;

    // emission
    logic [IDX_W-1:0]               emit_idx_reg;
    logic signed [W_WIDTH-1:0]      rd_w_reg;
    logic                           rd_miss_reg;
    logic signed [W_WIDTH-1:0]      res_reg;
    logic                           m_valid_reg;
    logic [W_WIDTH-1:0]             m_data_reg;
    logic                           m_last_reg;
    logic                           m_user_reg;

    // row store: miss mark above the weight
    logic [W_WIDTH:0]               row_mem [MAX_ROW_ENTRIES];

    logic signed [W_WIDTH-1:0]      in_w;
    logic [SRC_WIDTH-1:0]           in_src;
    logic                           in_miss;
    logic [IDX_W-1:0]               slot;
    logic [SUM_WIDTH-1:0]           sum_mag;
    logic                           tol_hit;
    logic signed [W_WIDTH-1:0]      direct_res;
    logic                           div_done;
    logic signed [W_WIDTH-1:0]      div_res;

    assign in_w    = s_tdata[W_WIDTH-1:0];
    assign in_src  = s_tdata[W_WIDTH+SRC_WIDTH-1:W_WIDTH];
    assign in_miss = (in_src == pattern_reg);
    assign slot    = entry_count_reg[IDX_W-1:0];

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= '0;
            tol_reg     <= TOL_WIDTH'(1);
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MISSING_PATTERN: pattern_reg <= cfg_wdata;
                CFG_ZERO_TOLERANCE:  tol_reg     <= cfg_wdata[TOL_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // row statistics: cleared at row end, updated on each accepted entry
    always_comb begin
        entry_count_next   = entry_count_reg;
        missing_count_next = missing_count_reg;
        kept_sum_next      = kept_sum_reg;
        heavy_w_next       = heavy_w_reg;
        heavy_miss_next    = heavy_miss_reg;
        last_miss_next     = last_miss_reg;
        if (cmd.clear_row) begin
            entry_count_next   = '0;
            missing_count_next = '0;
            kept_sum_next      = '0;
            heavy_w_next       = Q_MINUS_ONE;
            heavy_miss_next    = 1'b0;
            last_miss_next     = '0;
        end else if (cmd.accept) begin
            entry_count_next = entry_count_reg + CNT_W'(1);
            if (in_miss) begin
                missing_count_next = missing_count_reg + CNT_W'(1);
                last_miss_next     = slot;
            end else begin
                kept_sum_next = kept_sum_reg
                              + {{(SUM_WIDTH-W_WIDTH){in_w[W_WIDTH-1]}}, in_w};
            end
            if (heavy_w_reg < in_w) begin
                heavy_w_next    = in_w;
                heavy_miss_next = in_miss;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg   <= '0;
            missing_count_reg <= '0;
            kept_sum_reg      <= '0;
            heavy_w_reg       <= Q_MINUS_ONE;
            heavy_miss_reg    <= 1'b0;
            last_miss_reg     <= '0;
        end else begin
            entry_count_reg   <= entry_count_next;
            missing_count_reg <= missing_count_next;
            kept_sum_reg      <= kept_sum_next;
            heavy_w_reg       <= heavy_w_next;
            heavy_miss_reg    <= heavy_miss_next;
            last_miss_reg     <= last_miss_next;
        end
    end

    // row store write and registered read
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            row_mem[slot] <= {in_miss, in_w};
        end
        if (cmd.rd) begin
            {rd_miss_reg, rd_w_reg} <= row_mem[emit_idx_reg];
        end
    end

    // row end decision
    always_comb begin
        sum_mag = kept_sum_reg[SUM_WIDTH-1] ? SUM_WIDTH'(-kept_sum_reg) : kept_sum_reg;
        tol_hit = sum_mag <= {{(SUM_WIDTH-TOL_WIDTH){1'b0}}, tol_reg};
    end

    always_ff @(posedge aclk) begin
        if (cmd.decide) begin
            changed_reg <= (missing_count_reg != '0);
            one_hot_reg <= (missing_count_reg == entry_count_reg) | heavy_miss_reg | tol_hit;
            sum_mag_reg <= sum_mag;
            sum_neg_reg <= kept_sum_reg[SUM_WIDTH-1];
        end
    end

    // emit index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            emit_idx_reg <= '0;
        end else if (cmd.decide) begin
            emit_idx_reg <= '0;
        end else if (cmd.push) begin
            emit_idx_reg <= emit_idx_reg + IDX_W'(1);
        end
    end

    // results that need no division
    always_comb begin
        if (!changed_reg) begin
            direct_res = rd_w_reg;
        end else if (one_hot_reg) begin
            direct_res = (emit_idx_reg == last_miss_reg) ? Q_ONE : Q_ZERO;
        end else begin
            direct_res = Q_ZERO;
        end
    end

    // shared divider for kept entries
    mwrr_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .weight  (rd_w_reg),
        .sum_mag (sum_mag_reg),
        .sum_neg (sum_neg_reg),
        .done    (div_done),
        .result  (div_res)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load_direct) begin
            res_reg <= direct_res;
        end else if (cmd.div_take) begin
            res_reg <= div_res;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.push) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            m_data_reg <= res_reg;
            m_last_reg <= stat.last_entry;
            m_user_reg <= changed_reg;
        end
    end

    // status to the controller
    always_comb begin
        stat.row_close  = s_tlast | (slot == IDX_W'(MAX_ROW_ENTRIES - 1));
        stat.need_div   = changed_reg & ~one_hot_reg & ~rd_miss_reg;
        stat.div_done   = div_done;
        stat.out_free   = ~m_valid_reg | m_tready;
        stat.last_entry = (CNT_W'(emit_idx_reg) + CNT_W'(1)) == entry_count_reg;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

endmodule

>>> design/mwrr_ctrl.sv
// ----------------------------------------------------------------------------
// mwrr_ctrl
// Sequencer of the renormalizer: collects a row, takes the row decision,
// then reads, corrects and pushes each stored entry in turn.
// ----------------------------------------------------------------------------
module mwrr_ctrl
    import mwrr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  mwrr_stat_t  stat,
    output mwrr_cmd_t   cmd
);

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_COLLECT;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_COLLECT: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid && stat.row_close) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = ST_READ;
            end
            ST_READ: begin
                cmd.rd     = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (stat.need_div) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end else begin
                    cmd.load_direct = 1'b1;
                    state_next      = ST_PUSH;
                end
            end
            ST_DIV: begin
                if (stat.div_done) begin
                    cmd.div_take = 1'b1;
                    state_next   = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (stat.out_free) begin
                    cmd.push = 1'b1;
                    if (stat.last_entry) begin
                        cmd.clear_row = 1'b1;
                        state_next    = ST_COLLECT;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            default: state_next = ST_COLLECT;
        endcase
    end

endmodule

>>> design/missing_weight_row_renormalizer_unit.sv
// ----------------------------------------------------------------------------
// missing_weight_row_renormalizer_unit
// Renormalizes one row of interpolation weights after missing sources.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel brings one row entry per request: weight and raw source
//   pattern in s_tdata, s_tlast on the last entry of the row. A row also
//   closes when it fills MAX_ROW_ENTRIES slots. Entries are taken one per
//   cycle while a row is collected.
//   At row end the m_ channel returns one corrected weight per entry in
//   arrival order, m_tlast on the last one, m_tuser set on every result of a
//   row that held a missing entry.
//   After the closing entry the sequencer takes the row decision, then for
//   each entry reads it, loads a direct result or runs it through the shared
//   divider, which retires two quotient bits a cycle, and pushes the result;
//   an entry is finished before the next one is read.
//   A stalled m_ receiver holds the output register and the sequencer waits;
//   the next row is accepted while the final result still waits.
//   Reset (aresetn low, synchronous) clears the row statistics, sets
//   missing_pattern to 0 and zero_tolerance to 1, and leaves no result.
//   The user lets cfg_we/cfg_index/cfg_wdata write a register only while
//   the block idles; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module missing_weight_row_renormalizer_unit
    import mwrr_pkg::*;
#(
    parameter int MAX_ROW_ENTRIES = 32
)
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    // row entries
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,    // [31:0] weight, [95:32] source_value
    input  logic        s_tlast,    // row_end
    // corrected weights
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] new_weight
    output logic        m_tlast,    // last_of_row
    output logic        m_tuser     // [0] row_changed
);

    mwrr_cmd_t  cmd;
    mwrr_stat_t stat;

    // sequencer
    mwrr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // row store and arithmetic
    mwrr_datapath #(
        .MAX_ROW_ENTRIES (MAX_ROW_ENTRIES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

`ifndef SYNTHESIS
    // a result is pushed only into a free output register
    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> stat.out_free)
        else $error("result pushed over a waiting result");

    // the divider never finishes while entries are being collected
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.div_done |-> !s_tready)
        else $error("divider finished during collection");

    // after the last result of a row the block takes entries again
    a_row_reopen: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.push && stat.last_entry) |=> s_tready)
        else $error("row not reopened after last result");
`endif

endmodule

>>> test/tb_missing_weight_row_renormalizer_unit.sv
// ----------------------------------------------------------------------------
// tb_missing_weight_row_renormalizer_unit
// Self-checking bench for the weight row renormalizer. Rows of weight and
// source pattern requests go in on the s_ channel under random pacing, a
// local row model predicts every corrected weight, and each result taken on
// the m_ channel is compared field by field against the oldest prediction.
// Directed rows cover pass-through, one-hot fallback, renormalization with
// saturation, tie and tolerance corner cases; random rows follow under
// several register settings.
// ----------------------------------------------------------------------------
module tb_missing_weight_row_renormalizer_unit
    import mwrr_pkg::*;
();

    localparam int MAX_ROW     = 32;
    localparam int STALL_LIMIT = 3000;
    localparam int LONG_HOLD   = 400;
    localparam int SETTLE      = 40;

    typedef struct {
        logic signed [31:0] weight;
        logic [63:0]        source;
        logic               row_end;
    } row_entry_t;

    typedef struct {
        logic signed [31:0] weight;
        logic               last;
        logic               changed;
    } corrected_t;

    // dut ports
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [63:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata   = '0;    // [31:0] weight, [95:32] source_value
    logic        s_tlast   = 1'b0;  // row_end
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;           // [31:0] new_weight
    logic        m_tlast;           // last_of_row
    logic        m_tuser;           // [0] row_changed

    missing_weight_row_renormalizer_unit #(
        .MAX_ROW_ENTRIES(MAX_ROW)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .m_tuser(m_tuser)
    );

    always #5 aclk = ~aclk;

    // row model state
    logic [63:0]        miss_pat;
    logic [29:0]        zero_tol;
    logic signed [31:0] row_weights [MAX_ROW];
    logic               row_missing [MAX_ROW];
    logic [5:0]         row_len;
    logic [5:0]         row_miss_cnt;
    logic signed [37:0] row_sum;
    logic signed [31:0] top_weight;
    logic               top_is_missing;
    logic [4:0]         last_miss_slot;

    corrected_t corrected_q [$];
    row_entry_t pending_entries [$];

    int mismatches    = 0;
    int entries_taken = 0;
    int results_taken = 0;
    int idle_cycles   = 0;
    int rx_hold_req   = 0;
    corrected_t want;

    // back to the empty-row statistics
    function automatic void clear_row_stats();
        row_len        = '0;
        row_miss_cnt   = '0;
        row_sum        = '0;
        top_weight     = Q_MINUS_ONE;
        top_is_missing = 1'b0;
        last_miss_slot = '0;
    endfunction

    // weight * 2^30 / sum, ties away from zero, saturated
    function automatic logic signed [31:0] renorm_weight(logic signed [31:0] w,
                                                         logic signed [37:0] sum);
        bit          neg;
        longint      wl;
        longint      sl;
        logic [63:0] mw;
        logic [63:0] ms;
        logic [63:0] q;
        neg = (w < 0) != (sum < 0);
        wl  = w;
        sl  = sum;
        mw  = (wl < 0) ? -wl : wl;
        ms  = (sl < 0) ? -sl : sl;
        q   = (2 * (mw << 30) + ms) / (2 * ms);
        if (neg) begin
            if (q >= 64'h8000_0000)
                return W_MIN;
            return -$signed(q[31:0]);
        end
        if (q > 64'h7FFF_FFFF)
            return W_MAX;
        return q[31:0];
    endfunction

    // take one entry; on row close queue the corrected weights
    task automatic renormalize_entry(logic signed [31:0] w, logic [63:0] src, logic row_end);
        logic [5:0]         slot;
        logic               miss;
        logic               changed;
        logic               one_hot;
        logic signed [37:0] mag;
        corrected_t         r;
        slot = row_len;
        if (slot >= MAX_ROW)
            slot = MAX_ROW - 1;
        miss = (src == miss_pat);
        row_weights[slot] = w;
        row_missing[slot] = miss;
        if (miss) begin
            row_miss_cnt   = row_miss_cnt + 1;
            last_miss_slot = slot[4:0];
        end else begin
            row_sum = row_sum + w;
        end
        if (top_weight < w) begin
            top_weight     = w;
            top_is_missing = miss;
        end
        row_len = slot + 1;
        if (!row_end && row_len < MAX_ROW)
            return;

        changed = (row_miss_cnt != 0);
        mag     = (row_sum < 0) ? -row_sum : row_sum;
        one_hot = (row_miss_cnt == row_len) || top_is_missing || (mag <= {8'd0, zero_tol});
        for (int i = 0; i < row_len; i++) begin
            if (!changed)
                r.weight = row_weights[i];
            else if (one_hot)
                r.weight = (i == last_miss_slot) ? Q_ONE : Q_ZERO;
            else if (row_missing[i])
                r.weight = Q_ZERO;
            else
                r.weight = renorm_weight(row_weights[i], row_sum);
            r.last    = (i + 1 == row_len);
            r.changed = changed;
            corrected_q.push_back(r);
        end
        clear_row_stats();
    endtask

    // model update, result check and watchdog at the rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            miss_pat = '0;
            zero_tol = 30'd1;
            clear_row_stats();
        end else begin
            if (cfg_we) begin
                case (cfg_index_t'(cfg_index))
                    CFG_MISSING_PATTERN: miss_pat = cfg_wdata;
                    CFG_ZERO_TOLERANCE:  zero_tol = cfg_wdata[29:0];
                endcase
            end
            idle_cycles++;
            if (s_tvalid && s_tready) begin
                renormalize_entry(s_tdata[31:0], s_tdata[95:32], s_tlast);
                entries_taken++;
                idle_cycles = 0;
            end
            if (m_tvalid && m_tready) begin
                results_taken++;
                idle_cycles = 0;
                if (corrected_q.size() == 0) begin
                    $display("%0t: result with no prediction pending: new_weight %h", $time,
                             m_tdata);
                    mismatches++;
                end else begin
                    want = corrected_q.pop_front();
                    if (m_tdata !== want.weight) begin
                        $display("%0t: new_weight expected %h actual %h", $time, want.weight,
                                 m_tdata);
                        mismatches++;
                    end
                    if (m_tlast !== want.last) begin
                        $display("%0t: last_of_row expected %b actual %b", $time, want.last,
                                 m_tlast);
                        mismatches++;
                    end
                    if (m_tuser !== want.changed) begin
                        $display("%0t: row_changed expected %b actual %b", $time, want.changed,
                                 m_tuser);
                        mismatches++;
                    end
                end
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: watchdog, no request moved for %0d cycles", $time, idle_cycles);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // entry driver with random gaps
    int tx_seen    = 0;
    int tx_gap     = 0;
    int tx_stretch = 0;
    bit tx_calm    = 1'b0;
    bit tx_busy    = 1'b0;
    row_entry_t tx_cur;

    always @(negedge aclk) begin
        if (aresetn) begin
            if (tx_seen != entries_taken) begin
                tx_seen = entries_taken;
                tx_busy = 1'b0;
                if (tx_stretch == 0) begin
                    tx_calm    = $urandom_range(0, 1);
                    tx_stretch = $urandom_range(10, 60);
                end
                tx_stretch--;
                tx_gap = tx_calm ? 0 : $urandom_range(0, 11);
            end
            if (!tx_busy) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_entries.size() != 0) begin
                    tx_cur   = pending_entries.pop_front();
                    tx_busy  = 1'b1;
                    s_tvalid <= 1'b1;
                    s_tdata  <= {tx_cur.source, tx_cur.weight};
                    s_tlast  <= tx_cur.row_end;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result receiver with random stalls and the long hold
    int rx_seen      = 0;
    int rx_gap       = 0;
    int rx_stretch   = 0;
    int rx_hold_seen = 0;
    bit rx_calm      = 1'b0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (rx_seen != results_taken) begin
                rx_seen = results_taken;
                if (rx_stretch == 0) begin
                    rx_calm    = $urandom_range(0, 1);
                    rx_stretch = $urandom_range(10, 60);
                end
                rx_stretch--;
                rx_gap = rx_calm ? 0 : $urandom_range(0, 11);
            end
            if (rx_hold_seen != rx_hold_req) begin
                rx_hold_seen = rx_hold_req;
                rx_gap       = LONG_HOLD;
            end
            if (rx_gap > 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // stimulus helpers
    task automatic add_entry(logic signed [31:0] w, logic [63:0] src, logic row_end);
        row_entry_t e;
        e.weight  = w;
        e.source  = src;
        e.row_end = row_end;
        pending_entries.push_back(e);
    endtask

    function automatic logic signed [31:0] draw_weight();
        logic signed [31:0] w;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0:       w = W_MAX;
                    1:       w = W_MIN;
                    2:       w = Q_ZERO;
                    3:       w = Q_ONE;
                    default: w = Q_MINUS_ONE;
                endcase
            end
            1, 2: w = $urandom;
            3: begin
                w = $urandom_range(0, 32'h4000_0000);
                w = -w;
            end
            default: w = $urandom_range(0, 32'h4000_0000);
        endcase
        return w;
    endfunction

    function automatic logic [63:0] draw_source(int miss_pct);
        logic [63:0] s;
        if ($urandom_range(1, 100) <= miss_pct) begin
            s = miss_pat;
        end else begin
            s = {$urandom, $urandom};
            // near miss: one bit off the pattern
            if ($urandom_range(0, 7) == 0)
                s = miss_pat ^ (64'd1 << $urandom_range(0, 63));
        end
        return s;
    endfunction

    // whole rows with random content until the item count is reached
    task automatic add_random_rows(int items);
        int added;
        int len;
        int pct;
        bit closed;
        added = 0;
        while (added < items) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13: len = $urandom_range(1, 6);
                14, 15, 16, 17, 18:                            len = $urandom_range(7, 16);
                default:                                       len = MAX_ROW;
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2: pct = 0;
                3:       pct = 100;
                default: pct = 35;
            endcase
            // a full row may also close by filling the last slot
            closed = (len < MAX_ROW) || $urandom_range(0, 1);
            for (int k = 0; k < len; k++)
                add_entry(draw_weight(), draw_source(pct), (k == len - 1) && closed);
            added += len;
        end
    endtask

    task automatic write_reg(cfg_index_t idx, logic [63:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // sender holds back until every predicted result is out
    task automatic wait_idle();
        while (pending_entries.size() != 0 || tx_busy || corrected_q.size() != 0)
            @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // single entry, nothing missing: passes through
        add_entry(W_MAX, 64'hDEAD_BEEF_0123_4567, 1'b1);
        // heaviest entry is missing: one-hot
        add_entry(W_MIN, '1, 1'b0);
        add_entry(32'sh2000_0000, 64'd0, 1'b1);
        // every entry missing
        add_entry(32'sd5, 64'd0, 1'b0);
        add_entry(-32'sd3, 64'd0, 1'b1);
        // plain renormalization over a kept sum of 0.75
        add_entry(32'sh2000_0000, 64'd1, 1'b0);
        add_entry(32'sh1000_0000, 64'd0, 1'b0);
        add_entry(32'sh1000_0000, 64'd2, 1'b1);
        // tiny kept sum: quotients saturate both ways
        add_entry(W_MAX, 64'd1, 1'b0);
        add_entry(32'sh8000_0010, 64'd2, 1'b0);
        add_entry(Q_ZERO, 64'd0, 1'b1);
        // kept sum cancels to zero: one-hot
        add_entry(Q_ONE, 64'd7, 1'b0);
        add_entry(Q_MINUS_ONE, 64'd8, 1'b0);
        add_entry(Q_ZERO, 64'd0, 1'b1);
        // all weights at or below -1.0: heaviest keeps its reset value
        add_entry(W_MIN, 64'd0, 1'b0);
        add_entry(Q_MINUS_ONE, 64'd3, 1'b1);
        // tie on the greatest weight: the first one wins
        add_entry(32'sh2000_0000, 64'd1, 1'b0);
        add_entry(32'sh2000_0000, 64'd0, 1'b0);
        add_entry(32'sh0666_6666, 64'd2, 1'b1);
        wait_idle();

        // zero tolerance: only an exact zero sum falls back to one-hot
        write_reg(CFG_MISSING_PATTERN, {$urandom, $urandom});
        write_reg(CFG_ZERO_TOLERANCE, 64'd0);
        add_entry(Q_ONE, 64'd1, 1'b0);
        add_entry(32'shC000_0001, 64'd2, 1'b0);
        add_entry(32'sd5, miss_pat, 1'b1);
        add_entry(Q_ONE, 64'd1, 1'b0);
        add_entry(Q_MINUS_ONE, 64'd2, 1'b0);
        add_entry(32'sd5, miss_pat, 1'b1);
        add_random_rows(80);
        wait_idle();

        // all-ones pattern, widest tolerance
        write_reg(CFG_MISSING_PATTERN, '1);
        write_reg(CFG_ZERO_TOLERANCE, 64'h3FFF_FFFF);
        add_random_rows(70);
        wait_idle();

        // receiver stalls for a long stretch while rows keep coming
        write_reg(CFG_MISSING_PATTERN, {$urandom, $urandom});
        write_reg(CFG_ZERO_TOLERANCE, 64'($urandom_range(0, 16'hFFFF)));
        rx_hold_req++;
        add_random_rows(90);
        wait_idle();

        // back to the reset settings
        write_reg(CFG_MISSING_PATTERN, 64'd0);
        write_reg(CFG_ZERO_TOLERANCE, 64'd1);
        add_random_rows(90);
        wait_idle();

        write_reg(CFG_MISSING_PATTERN, {$urandom, $urandom});
        write_reg(CFG_ZERO_TOLERANCE, 64'h1000);
        add_random_rows(50);
        wait_idle();

        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> missing_weight_row_renormalizer_unit.f
design/mwrr_pkg.sv
design/mwrr_divider.sv
design/mwrr_datapath.sv
design/mwrr_ctrl.sv
design/missing_weight_row_renormalizer_unit.sv
test/tb_missing_weight_row_renormalizer_unit.sv
